// File: hdl/isort_pkg.sv
// ----------------------------------------------------------------------------
// isort_pkg
// shared constants and types of the insertion sort engine
// ----------------------------------------------------------------------------
package isort_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 64;

    typedef logic signed [DATA_W-1:0] data_t;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic  load;   // insert key into the sorted row
        logic  shift;  // move the row one place towards cell 0
        data_t key;    // value being inserted
    } cell_ctrl_t;

endpackage

// File: hdl/isort_cell.sv
// ----------------------------------------------------------------------------
// isort_cell
// one slot of the sorted row: compare-and-shift on insert, shift down on drain
// ----------------------------------------------------------------------------
module isort_cell (
    input  logic                   aclk,
    input  isort_pkg::cell_ctrl_t  ctrl,
    input  logic                   occupied,
    input  isort_pkg::data_t       left_value,
    input  logic                   left_gt,
    input  isort_pkg::data_t       right_value,
    output isort_pkg::data_t       value,
    output logic                   gt
);
    import isort_pkg::*;

    data_t value_reg;
    data_t value_next;

    // stored entry is strictly greater than the new key, so it moves up
    assign gt    = occupied && (value_reg > ctrl.key);
    assign value = value_reg;

    always_comb begin
        value_next = value_reg;
        if (ctrl.load) begin
            if (!gt && occupied) begin
                value_next = value_reg;
            end else if (!left_gt) begin
                value_next = ctrl.key;
            end else begin
                value_next = left_value;
            end
        end else if (ctrl.shift) begin
            value_next = right_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

// File: hdl/insertion_sort_engine_unit.sv
// ----------------------------------------------------------------------------
// insertion_sort_engine_unit
// streaming insertion sorter built from a chain of compare-and-shift cells
// ----------------------------------------------------------------------------
// usage:
//   s_ channel takes one signed value per beat; s_last marks the end of a
//   batch. while loading, s_ready is high and one beat is taken every cycle
//   that s_valid is high: each value is broadcast to the chain and inserted
//   by all cells in parallel, equal values staying in arrival order.
//   after the last beat the block stops taking input and drains the row on
//   the m_ channel in ascending order, one beat per cycle that m_ready is
//   high, starting the cycle after the last input beat. m_last_out marks the
//   final beat; m_overflow is high on every beat of a batch that brought more
//   than DEPTH values (the surplus is dropped).
//   the row drains through the single shift path towards cell 0.
//   a stalled receiver simply holds the row; nothing is lost.
//   reset empties the row and returns to loading; the cell contents are not
//   cleared, only the fill count and the overflow flag.
// ----------------------------------------------------------------------------
module insertion_sort_engine_unit #(
    parameter int DEPTH = isort_pkg::DEPTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  isort_pkg::data_t        s_value,
    input  logic                    s_last,
    output logic                    m_valid,
    input  logic                    m_ready,
    output isort_pkg::data_t        m_sorted_value,
    output logic                    m_last_out,
    output logic                    m_overflow
);
    import isort_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg;
    logic             dropped_reg;

    cell_ctrl_t       ctrl;
    logic             s_beat;
    logic             m_beat;
    logic             room;

    data_t            cell_value [DEPTH];
    logic [DEPTH-1:0] cell_gt;
    logic [DEPTH-1:0] cell_occ;

    assign s_ready = (state_reg == ST_LOAD);
    assign m_valid = (state_reg == ST_DRAIN);
    assign s_beat  = s_valid && s_ready;
    assign m_beat  = m_valid && m_ready;
    assign room    = (count_reg < CNT_W'(DEPTH));

    assign ctrl.load  = s_beat && room;
    assign ctrl.shift = m_beat;
    assign ctrl.key   = s_value;

    assign m_sorted_value = cell_value[0];
    assign m_last_out     = (count_reg == CNT_W'(1));
    assign m_overflow     = dropped_reg;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        assign cell_occ[i] = (CNT_W'(i) < count_reg);

        isort_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .occupied    (cell_occ[i]),
            .left_value  ((i == 0) ? s_value : cell_value[(i == 0) ? 0 : i - 1]),
            .left_gt     ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
            .right_value (cell_value[(i == DEPTH - 1) ? i : i + 1]),
            .value       (cell_value[i]),
            .gt          (cell_gt[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    if (s_beat) begin
                        if (room) begin
                            count_reg <= count_reg + CNT_W'(1);
                        end else begin
                            dropped_reg <= 1'b1;
                        end
                        if (s_last) begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (m_beat) begin
                        count_reg <= count_reg - CNT_W'(1);
                        if (count_reg == CNT_W'(1)) begin
                            state_reg   <= ST_LOAD;
                            dropped_reg <= 1'b0;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    // a draining row is never empty
    a_drain_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (count_reg != '0))
        else $error("drain with empty row");

    // the last input beat starts the drain in the next cycle
    a_last_starts_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && s_last) |=> (m_valid && !s_ready))
        else $error("last beat did not start drain");

    // fill count never exceeds the row length
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    // the final output beat hands control back to loading
    a_final_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_beat && m_last_out) |=> (s_ready && !m_valid && count_reg == '0))
        else $error("final beat did not return to load");

endmodule
